/* rtl/tbf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer package
// Opcodes, job descriptor passed from the front end to the write sequencer,
// and fixed framing constants.
// ----------------------------------------------------------------------------
package tbf_pkg;

  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned COUNT_W = 16;

  localparam logic [1:0] OP_DATA        = 2'd0;
  localparam logic [1:0] OP_CLOSE_NONEMPTY = 2'd1;
  localparam logic [1:0] OP_CLOSE_ALWAYS = 2'd2;
  localparam logic [1:0] OP_RESTART     = 2'd3;

  localparam logic [COUNT_W-1:0] BLOCK_MAX_DATA = 16'd65534;

  // beat index of the final write of a close job
  localparam logic [1:0] CLOSE_LAST_STEP = 2'd2;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_OVF,
    JOB_CLOSE
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [SIZE_W-1:0]  addr_a;   // data byte or checksum address
    logic [7:0]         byte_a;   // data byte or checksum
    logic [SIZE_W-1:0]  addr_lo;  // length low byte address
    logic [SIZE_W-1:0]  addr_hi;  // length high byte address
    logic [COUNT_W-1:0] len;      // block length including checksum
    logic [SIZE_W-1:0]  size;     // image size after this item
  } job_t;

endpackage

/* rtl/tbf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer front end
// Accepts opcodes, keeps file size, block count and checksum, and turns each
// data byte and each block close into a job descriptor for the write sequencer.
// ----------------------------------------------------------------------------
module tbf_front #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_byte,
  input  logic               q_full,
  output logic               job_valid,
  output tbf_pkg::job_t      job
);

  localparam logic [tbf_pkg::SIZE_W-1:0] ADDR_MASK = (ADDR_BITS >= 24) ? 24'hFFFFFF :
    tbf_pkg::SIZE_W'((33'd1 << ADDR_BITS) - 33'd1);

  logic [tbf_pkg::SIZE_W-1:0]  file_size_r, file_size_nxt;
  logic [tbf_pkg::COUNT_W-1:0] block_count_r, block_count_nxt;
  logic [7:0]                  xor_sum_r, xor_sum_nxt;

  logic                        accept;
  logic [tbf_pkg::SIZE_W-1:0]  next_addr;
  logic [tbf_pkg::COUNT_W-1:0] len;
  logic [tbf_pkg::SIZE_W-1:0]  closed_size;
  logic                        emit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign next_addr   = file_size_r + 24'd2 + {8'd0, block_count_r};
  assign len         = block_count_r + 16'd1;
  assign closed_size = file_size_r + 24'd2 + {8'd0, len};

  always_comb begin
    file_size_nxt   = file_size_r;
    block_count_nxt = block_count_r;
    xor_sum_nxt     = xor_sum_r;
    emit            = 1'b0;
    job.kind        = tbf_pkg::JOB_DATA;
    job.addr_a      = next_addr & ADDR_MASK;
    job.byte_a      = in_byte;
    job.addr_lo     = file_size_r & ADDR_MASK;
    job.addr_hi     = (file_size_r + 24'd1) & ADDR_MASK;
    job.len         = len;
    job.size        = file_size_r;
    unique case (in_opcode)
      tbf_pkg::OP_DATA: begin
        emit = 1'b1;
        if (block_count_r >= tbf_pkg::BLOCK_MAX_DATA) begin
          job.kind   = tbf_pkg::JOB_OVF;
          job.addr_a = '0;
          job.byte_a = '0;
        end else begin
          block_count_nxt = block_count_r + 16'd1;
          xor_sum_nxt     = xor_sum_r ^ in_byte;
        end
      end
      tbf_pkg::OP_CLOSE_NONEMPTY, tbf_pkg::OP_CLOSE_ALWAYS: begin
        if (in_opcode == tbf_pkg::OP_CLOSE_ALWAYS || block_count_r != '0) begin
          emit            = 1'b1;
          job.kind        = tbf_pkg::JOB_CLOSE;
          job.byte_a      = xor_sum_r;
          job.size        = closed_size;
          file_size_nxt   = closed_size;
          block_count_nxt = '0;
          xor_sum_nxt     = '0;
        end
      end
      tbf_pkg::OP_RESTART: begin
        file_size_nxt   = '0;
        block_count_nxt = '0;
        xor_sum_nxt     = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign job_valid = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r   <= '0;
      block_count_r <= '0;
      xor_sum_r     <= '0;
    end else if (accept) begin
      file_size_r   <= file_size_nxt;
      block_count_r <= block_count_nxt;
      xor_sum_r     <= xor_sum_nxt;
    end
  end

endmodule

/* rtl/tbf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer job queue
// Two-entry queue of job descriptors between the front end and the write
// sequencer.
// ----------------------------------------------------------------------------
module tbf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  tbf_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output tbf_pkg::job_t rd_job
);

  tbf_pkg::job_t entry_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/tbf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer write sequencer
// Pops job descriptors and issues one write beat per data byte or overflow
// marker and three beats per block close, through an output register.
// ----------------------------------------------------------------------------
module tbf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  input  tbf_pkg::job_t              job,
  output logic                       job_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tbf_pkg::SIZE_W-1:0] out_write_addr,
  output logic [7:0]                 out_write_byte,
  output logic                       out_last,
  output logic [tbf_pkg::SIZE_W-1:0] out_image_size,
  output logic                       out_overflow
);

  logic                       out_valid_r;
  logic [1:0]                 step_r, step_nxt;
  logic [tbf_pkg::SIZE_W-1:0] addr_r, addr_nxt;
  logic [7:0]                 byte_r, byte_nxt;
  logic                       last_r, last_nxt;
  logic [tbf_pkg::SIZE_W-1:0] size_r;
  logic                       ovf_r;
  logic                       load;
  logic                       issue;

  assign load    = !out_valid_r || !out_stall;
  assign issue   = load && job_valid;
  assign job_pop = issue && last_nxt;

  always_comb begin
    addr_nxt = job.addr_a;
    byte_nxt = job.byte_a;
    last_nxt = 1'b1;
    step_nxt = '0;
    if (job.kind == tbf_pkg::JOB_CLOSE) begin
      unique case (step_r)
        2'd0: begin
          last_nxt = 1'b0;
          step_nxt = 2'd1;
        end
        2'd1: begin
          addr_nxt = job.addr_lo;
          byte_nxt = job.len[7:0];
          last_nxt = 1'b0;
          step_nxt = tbf_pkg::CLOSE_LAST_STEP;
        end
        default: begin
          addr_nxt = job.addr_hi;
          byte_nxt = job.len[15:8];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (load) begin
      out_valid_r <= job_valid;
      if (job_valid) begin
        step_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      addr_r <= addr_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      size_r <= job.size;
      ovf_r  <= (job.kind == tbf_pkg::JOB_OVF);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_write_addr = addr_r;
  assign out_write_byte = byte_r;
  assign out_last       = last_r;
  assign out_image_size = size_r;
  assign out_overflow   = ovf_r;

endmodule

/* rtl/tape_block_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer
// Frames a byte stream into tape blocks (length, data, XOR checksum) and
// issues the byte writes that build the tape image.
// Path: an accepted item is written into the job queue; the write sequencer then
// loads its first write beat into the output register.
// Throughput: one data byte per cycle unless out_stall or a full job queue holds
// it; a close takes three write beats, buffered by a two-entry job queue.
// Reset: synchronous, active low; clears file size, block count, checksum,
// the job queue, the output valid flag and the close step counter.
// ----------------------------------------------------------------------------
module tape_block_framer #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_write_addr,
  output logic [7:0]  out_write_byte,
  output logic        out_last,
  output logic [23:0] out_image_size,
  output logic        out_overflow
);

  logic          front_job_valid;
  tbf_pkg::job_t front_job;
  logic          q_full;
  logic          q_valid;
  tbf_pkg::job_t q_job;
  logic          q_pop;

  tbf_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .job_valid (front_job_valid),
    .job       (front_job)
  );

  tbf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (front_job_valid),
    .wr_job   (front_job),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  tbf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_valid),
    .job            (q_job),
    .job_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_write_addr (out_write_addr),
    .out_write_byte (out_write_byte),
    .out_last       (out_last),
    .out_image_size (out_image_size),
    .out_overflow   (out_overflow)
  );

endmodule

/* sim/tbf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer checker
// Tracks the open block and the image size from every accepted input beat.
// It queues the image writes that each beat should cause, and compares every
// accepted write beat field by field with the oldest queued write.
// ----------------------------------------------------------------------------
module tbf_checker #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [23:0] out_write_addr,
  input  logic [7:0]  out_write_byte,
  input  logic        out_last,
  input  logic [23:0] out_image_size,
  input  logic        out_overflow,
  output int          fail_count,
  output int          pending,
  output int          beats_checked,
  output int          ovf_seen
);

  typedef struct packed {
    logic [tbf_pkg::SIZE_W-1:0] addr;
    logic [7:0]                 data;
    logic                       fin;
    logic [tbf_pkg::SIZE_W-1:0] size;
    logic                       ovf;
  } image_write_t;

  image_write_t                expected_writes[$];
  logic [tbf_pkg::SIZE_W-1:0]  img_size;
  logic [tbf_pkg::COUNT_W-1:0] blk_count;
  logic [7:0]                  blk_xor;

  function automatic logic [tbf_pkg::SIZE_W-1:0] image_addr(input logic [32:0] a);
    logic [32:0] mask;
    logic [32:0] masked;
    mask   = (33'd1 << ADDR_BITS) - 33'd1;
    masked = a & mask;
    return masked[tbf_pkg::SIZE_W-1:0];
  endfunction

  task automatic frame_beat(input logic [1:0] op, input logic [7:0] b);
    logic [tbf_pkg::SIZE_W-1:0]  base;
    logic [tbf_pkg::COUNT_W-1:0] len;
    base = img_size;
    len  = blk_count + 16'd1;
    case (op)
      tbf_pkg::OP_DATA: begin
        if (blk_count >= tbf_pkg::BLOCK_MAX_DATA) begin
          expected_writes.push_back('{addr: '0, data: '0, fin: 1'b1, size: img_size,
                                      ovf: 1'b1});
        end else begin
          expected_writes.push_back('{addr: image_addr(33'(base) + 33'd2 + 33'(blk_count)),
                                      data: b, fin: 1'b1, size: img_size, ovf: 1'b0});
          blk_count = len;
          blk_xor   = blk_xor ^ b;
        end
      end
      tbf_pkg::OP_CLOSE_NONEMPTY, tbf_pkg::OP_CLOSE_ALWAYS: begin
        if (op == tbf_pkg::OP_CLOSE_ALWAYS || blk_count != '0) begin
          img_size = base + 24'd2 + {8'd0, len};
          expected_writes.push_back('{addr: image_addr(33'(base) + 33'd2 + 33'(blk_count)),
                                      data: blk_xor, fin: 1'b0, size: img_size, ovf: 1'b0});
          expected_writes.push_back('{addr: image_addr(33'(base)), data: len[7:0], fin: 1'b0,
                                      size: img_size, ovf: 1'b0});
          expected_writes.push_back('{addr: image_addr(33'(base) + 33'd1), data: len[15:8],
                                      fin: 1'b1, size: img_size, ovf: 1'b0});
          blk_count = '0;
          blk_xor   = '0;
        end
      end
      tbf_pkg::OP_RESTART: begin
        img_size  = '0;
        blk_count = '0;
        blk_xor   = '0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    image_write_t want;
    if (!rst_n) begin
      img_size  = '0;
      blk_count = '0;
      blk_xor   = '0;
      expected_writes.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: write beat with none expected, got addr %h byte %h", $time,
                   out_write_addr, out_write_byte);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          check_field("write_addr", 32'(want.addr), 32'(out_write_addr));
          check_field("write_byte", 32'(want.data), 32'(out_write_byte));
          check_field("last", 32'(want.fin), 32'(out_last));
          check_field("image_size", 32'(want.size), 32'(out_image_size));
          check_field("overflow", 32'(want.ovf), 32'(out_overflow));
          beats_checked++;
          if (want.ovf) ovf_seen++;
        end
      end
      if (in_valid && !in_stall) frame_beat(in_opcode, in_byte);
      pending <= expected_writes.size();
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape block framer testbench
// Drives opcode beats into the framer: a short directed run of the corner
// cases, randomly sized blocks under changing idle patterns and receiver
// hold-offs, then a few directed closes.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned RANDOM_ITEMS = 410;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [1:0]  in_opcode = tbf_pkg::OP_DATA;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [23:0] out_write_addr;
  logic [7:0]  out_write_byte;
  logic        out_last;
  logic [23:0] out_image_size;
  logic        out_overflow;

  int          fail_count;
  int          pending;
  int          beats_checked;
  int          ovf_seen;
  int unsigned cycle_count  = 0;
  int unsigned beats_sent   = 0;
  int unsigned idle_in_pct  = 0;
  int unsigned idle_out_pct = 0;
  int unsigned hold_ask     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  tape_block_framer #(.ADDR_BITS(24)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_write_addr(out_write_addr),
    .out_write_byte(out_write_byte),
    .out_last      (out_last),
    .out_image_size(out_image_size),
    .out_overflow  (out_overflow)
  );

  tbf_checker #(.ADDR_BITS(24)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_write_addr(out_write_addr),
    .out_write_byte(out_write_byte),
    .out_last      (out_last),
    .out_image_size(out_image_size),
    .out_overflow  (out_overflow),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked),
    .ovf_seen      (ovf_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // hold off for a fixed stretch on request, else stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_out_pct);
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_byte   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_random_blocks(input int unsigned n_beats);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) len = 0;
      else if (pick < 90) len = $urandom_range(1, 12);
      else len = $urandom_range(13, 60);
      repeat (len) begin
        if ($urandom_range(0, 99) < 3) send_beat(tbf_pkg::OP_RESTART, 8'($urandom));
        else send_beat(tbf_pkg::OP_DATA, 8'($urandom));
        sent++;
      end
      pick = $urandom_range(0, 99);
      // leave the block open now and then so that it grows across rounds
      if (pick < 45) send_beat(tbf_pkg::OP_CLOSE_NONEMPTY, 8'($urandom));
      else if (pick < 88) send_beat(tbf_pkg::OP_CLOSE_ALWAYS, 8'($urandom));
      else if (pick < 94) send_beat(tbf_pkg::OP_RESTART, 8'($urandom));
      if (pick < 94) sent++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    idle_in_pct = 37;
    idle_out_pct <= 52;

    send_beat(tbf_pkg::OP_CLOSE_NONEMPTY, 8'hFF);
    send_beat(tbf_pkg::OP_CLOSE_ALWAYS, 8'hFF);
    send_beat(tbf_pkg::OP_DATA, 8'h00);
    send_beat(tbf_pkg::OP_DATA, 8'hFF);
    send_beat(tbf_pkg::OP_DATA, 8'hA5);
    send_beat(tbf_pkg::OP_CLOSE_NONEMPTY, 8'h00);
    send_beat(tbf_pkg::OP_CLOSE_NONEMPTY, 8'h5A);
    send_beat(tbf_pkg::OP_DATA, 8'h5A);
    send_beat(tbf_pkg::OP_RESTART, 8'hC3);
    send_beat(tbf_pkg::OP_CLOSE_ALWAYS, 8'h00);
    hold_ask <= hold_ask + 1;
    for (int i = 0; i < 10; i++) send_beat(tbf_pkg::OP_DATA, 8'(i * 37 + 1));
    send_beat(tbf_pkg::OP_CLOSE_ALWAYS, 8'h00);
    send_beat(tbf_pkg::OP_CLOSE_ALWAYS, 8'h80);

    send_random_blocks(RANDOM_ITEMS / 3);
    idle_in_pct = 52;
    idle_out_pct <= 37;
    hold_ask <= hold_ask + 1;
    send_random_blocks(RANDOM_ITEMS / 3);
    idle_in_pct = 0;
    idle_out_pct <= 0;
    send_random_blocks(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    idle_in_pct = 37;
    idle_out_pct <= 52;
    send_beat(tbf_pkg::OP_DATA, 8'hFF);
    send_beat(tbf_pkg::OP_DATA, 8'h00);
    send_beat(tbf_pkg::OP_DATA, 8'($urandom));
    send_beat(tbf_pkg::OP_CLOSE_NONEMPTY, 8'h00);
    send_beat(tbf_pkg::OP_DATA, 8'h3C);
    send_beat(tbf_pkg::OP_CLOSE_ALWAYS, 8'hFF);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d input beats in %0d cycles, including two long hold-offs",
             beats_sent, cycle_count);
    $display("checked %0d write beats, %0d of them overflow markers", beats_checked, ovf_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tbf_pkg.sv
rtl/tbf_front.sv
rtl/tbf_queue.sv
rtl/tbf_back.sv
rtl/tape_block_framer.sv
sim/tbf_checker.sv
sim/tb.sv
